// File: rtl/core/vertex_weight_norm_reducer_defines.svh
// Assertion macros shared by the checker of vertex_weight_norm_reducer.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef VERTEX_WEIGHT_NORM_REDUCER_DEFINES_SVH
`define VERTEX_WEIGHT_NORM_REDUCER_DEFINES_SVH

// Next-cycle implication, off while reset is held.
`define VWNR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication, off while reset is held.
`define VWNR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers reset cycles.
`define VWNR_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/vwnr_pkg.sv
// Types and constants of the vertex weight norm reducer.
// No dependencies; used by the top level and the square root unit.
package vwnr_pkg;

    localparam int ACC_W  = 64;   // accumulator width
    localparam int ROOT_W = 32;   // root of a 64-bit value
    localparam int OUT_W  = 32;   // norm_value width

    localparam logic [OUT_W-1:0] INT32_MAX_C = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] INT32_MIN_C = 32'h8000_0000;
    localparam logic [ACC_W-1:0] INT64_MAX_C = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] INT64_MIN_C = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_SUM  = 2'd1,
        MODE_EUCL = 2'd2,
        MODE_MAX  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_ROOT,
        ST_OUT
    } t_state;

endpackage

// File: rtl/core/vwnr_isqrt.sv
// Iterative floor square root of a 64-bit value, two radicand bits per cycle.
// Depends on vwnr_pkg.
module vwnr_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [vwnr_pkg::ACC_W-1:0]  i_operand,
    output logic                        o_done,
    output logic [vwnr_pkg::ROOT_W-1:0] o_root
);
    import vwnr_pkg::*;

    localparam int CntW = $clog2(ROOT_W);
    localparam int RemW = ROOT_W + 2;

    logic [ACC_W-1:0]  r_op;
    logic [RemW-1:0]   r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CntW-1:0]   r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [RemW+1:0]   rem_shift;
    logic [RemW+1:0]   trial;
    logic              ge;
    logic [RemW+1:0]   rem_diff;

    // rem <- rem*4 + next pair; try subtracting 4*root+1
    assign rem_shift = {r_rem, r_op[ACC_W-1 -: 2]};
    assign trial     = {2'b00, r_root, 2'b01};
    assign ge        = (rem_shift >= trial);
    assign rem_diff  = ge ? (rem_shift - trial) : rem_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= i_operand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_op   <= {r_op[ACC_W-3:0], 2'b00};
            r_rem  <= rem_diff[RemW-1:0];
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: rtl/core/vertex_weight_norm_reducer.sv
// Vertex weight norm reducer: top level, sequencer, accumulator and output register.
// Depends on vwnr_pkg and vwnr_isqrt.
//
//  channel  | dir | beat contents                        | handshake
//  ---------+-----+--------------------------------------+---------------------------
//  s_axis   | in  | tdata[31:0] weight, tlast last_weight | tvalid & tready
//  m_axis   | out | tdata[31:0] norm_value, tlast end     | tvalid & tready
//  cfg      | in  | i_cfg_wdata[1:0] norm_mode            | i_cfg_we, no wait
//
// Each weight beat is accepted, then passes the accumulate state. In pass mode and
// on the last weight of a sum or max vertex the output register is then loaded; on
// the last weight in euclidean mode the root unit first runs its 32 steps, and the
// output register is loaded after it.
// Reset is synchronous, active low; it clears the sequencer, mode and state.
// A result waiting in the output register does not block the next accept; only
// the load of a new result waits for the output register to drain.
module vertex_weight_norm_reducer #(
    parameter int WEIGHT_BITS = 32          // 8..32: used low bits of a weight
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,        // [1:0] norm_mode
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,       // [31:0] weight
    input  logic        s_axis_tlast,       // last_weight
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,       // [31:0] norm_value
    output logic        m_axis_tlast        // vertex_end
);
    import vwnr_pkg::*;

    localparam int SqW = 2 * WEIGHT_BITS;

    t_state r_state, n_state;
    t_mode  r_mode;

    // captured beat
    logic signed [WEIGHT_BITS-1:0] r_w;
    logic                          r_last;
    logic [SqW-1:0]                r_sq;

    // vertex state
    logic [ACC_W-1:0]              r_acc, n_acc;
    logic signed [WEIGHT_BITS-1:0] r_max, n_max;

    // output register
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic              r_out_last;

    logic in_beat;
    logic slot_free;
    logic out_load;
    logic root_start;
    logic root_done;
    logic [ROOT_W-1:0] root;

    logic signed [WEIGHT_BITS-1:0] w_in;
    logic signed [SqW-1:0]         w_sq;

    logic [ACC_W:0]   add_a, add_b, add_sum;
    logic [ACC_W-1:0] acc_sat;
    logic [OUT_W-1:0] result;

    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign slot_free = !r_out_valid || m_axis_tready;

    // Square taken at accept time; w*w is never negative, so the top bit is zero.
    assign w_in = s_axis_tdata[WEIGHT_BITS-1:0];
    assign w_sq = w_in * w_in;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_mode == MODE_PASS)      n_state = ST_OUT;
                else if (!r_last)             n_state = ST_IDLE;
                else if (r_mode == MODE_EUCL) n_state = ST_ROOT;
                else                          n_state = ST_OUT;
            end
            ST_ROOT: begin
                if (root_done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        root_start    = (r_state == ST_ACC) && r_last && (r_mode == MODE_EUCL);
        out_load      = (r_state == ST_OUT) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MODE_PASS;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_mode <= t_mode'(i_cfg_wdata);
        end
    end

    // ---------------- shared adder ----------------
    // One 65-bit adder: unsigned sum of squares in euclidean mode, signed sum otherwise.
    always_comb begin
        if (r_mode == MODE_EUCL) begin
            add_a = {1'b0, r_acc};
            add_b = (ACC_W + 1)'(r_sq);
        end else begin
            add_a = {r_acc[ACC_W-1], r_acc};
            add_b = (ACC_W + 1)'(r_w);
        end
        add_sum = add_a + add_b;

        if (r_mode == MODE_EUCL) begin
            acc_sat = add_sum[ACC_W] ? '1 : add_sum[ACC_W-1:0];
        end else if (add_sum[ACC_W] != add_sum[ACC_W-1]) begin
            // signed overflow: clamp toward the sign of the true sum
            acc_sat = add_sum[ACC_W] ? INT64_MIN_C : INT64_MAX_C;
        end else begin
            acc_sat = add_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        n_acc = r_acc;
        n_max = r_max;
        if (r_state == ST_ACC) begin
            if (r_mode == MODE_SUM || r_mode == MODE_EUCL) n_acc = acc_sat;
            if (r_mode == MODE_MAX && r_w > r_max)         n_max = r_w;
        end
        // every vertex end returns the state to zero, whatever the mode
        if (out_load && r_last) begin
            n_acc = '0;
            n_max = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_max <= '0;
        end else begin
            r_acc <= n_acc;
            r_max <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_w    <= w_in;
            r_last <= s_axis_tlast;
            r_sq   <= $unsigned(w_sq);
        end
    end

    // ---------------- root unit ----------------
    vwnr_isqrt u_isqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (root_start),
        .i_operand (n_acc),
        .o_done    (root_done),
        .o_root    (root)
    );

    // ---------------- result select ----------------
    always_comb begin
        case (r_mode)
            MODE_PASS: result = OUT_W'(r_w);
            MODE_SUM: begin
                // int32 saturation of the signed accumulator
                if (!r_acc[ACC_W-1] && (|r_acc[ACC_W-2:OUT_W-1]))
                    result = INT32_MAX_C;
                else if (r_acc[ACC_W-1] && !(&r_acc[ACC_W-2:OUT_W-1]))
                    result = INT32_MIN_C;
                else
                    result = r_acc[OUT_W-1:0];
            end
            MODE_EUCL: result = root[ROOT_W-1] ? INT32_MAX_C : OUT_W'(root);
            default:   result = OUT_W'(r_max);
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= result;
            r_out_last <= r_last;   // non-pass results only ever close a vertex
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

// File: rtl/core/vwnr_checker.sv
// Port-level checker of the vertex weight norm reducer, bound to the top level.
// Depends on vertex_weight_norm_reducer_defines.svh.
`include "vertex_weight_norm_reducer_defines.svh"

module vwnr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled result beat holds
    `VWNR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "result beat changed under stall")

    // reset leaves no result pending
    `VWNR_ASSERT_RST(a_rst_empty, !i_rst_n, !m_axis_tvalid, "result valid after reset")

    // one weight at a time: busy right after an accept
    `VWNR_ASSERT_NEXT(a_busy_after, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input ready right after accept")

    // a new result only appears out of a working cycle
    `VWNR_ASSERT_NOW(a_out_from_work, $rose(m_axis_tvalid), !$past(s_axis_tready),
        "result without work")

endmodule

bind vertex_weight_norm_reducer vwnr_checker u_vwnr_checker (.*);
